// ----- rtl/mcpd_pkg.sv -----
// Shared types and constants of the motor current pinch detector.
package mcpd_pkg;

  // Opcodes of a request
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_SUSPEND = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_HARD_THR  = 3'd0;
  localparam logic [2:0] REG_SOFT_THR  = 3'd1;
  localparam logic [2:0] REG_HARD_LIM  = 3'd2;
  localparam logic [2:0] REG_SOFT_LIM  = 3'd3;
  localparam logic [2:0] REG_IGNORE_MS = 3'd4;
  localparam logic [2:0] REG_STOP_EN   = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] HARD_THR_RST  = 16'd34000;
  localparam logic [15:0] SOFT_THR_RST  = 16'd4400;
  localparam logic [7:0]  HARD_LIM_RST  = 8'd2;
  localparam logic [7:0]  SOFT_LIM_RST  = 8'd3;
  localparam logic [15:0] IGNORE_MS_RST = 16'd300;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Result status codes
  localparam logic [2:0] ST_FROZEN    = 3'd0;
  localparam logic [2:0] ST_SUSPENDED = 3'd1;
  localparam logic [2:0] ST_IDLE      = 3'd2;
  localparam logic [2:0] ST_START     = 3'd3;
  localparam logic [2:0] ST_IGNORE    = 3'd4;
  localparam logic [2:0] ST_READ_FAIL = 3'd5;
  localparam logic [2:0] ST_EVAL      = 3'd6;
  localparam logic [2:0] ST_CMD_DONE  = 3'd7;

  // Request payload
  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        now_ms;
    logic               motor_moving;
    logic               read_ok;
    logic signed [15:0] shunt_raw;
    logic [31:0]        hold_ms;
  } in_t;

  // Result payload
  typedef struct packed {
    logic        detected;
    logic        trip;
    logic [7:0]  hard_count_out;
    logic [7:0]  soft_count_out;
    logic [18:0] window_total;
    logic [3:0]  window_fill;
    logic [2:0]  status;
  } out_t;

endpackage

// ----- rtl/mcpd_cell.sv -----
// One cell of the current window chain: holds a single current sample.
module mcpd_cell (
  input  logic        clk_i,
  input  logic        shift_en_i,
  input  logic [15:0] data_i,
  output logic [15:0] data_o
);

  logic [15:0] val_q;

  // take the neighbour's value on every push
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      val_q <= data_i;
    end
  end

  assign data_o = val_q;

endmodule

// ----- rtl/mcpd_obuf.sv -----
// Two-entry result buffer between the detector core and the output channel.
module mcpd_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mcpd_pkg::out_t    data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output mcpd_pkg::out_t    data_o
);

  logic           v0_q, v0_d, v1_q, v1_d;
  mcpd_pkg::out_t e0_q, e0_d, e1_q, e1_d;
  logic           pop;

  assign pop = v0_q && !stall_i;

  // head/tail update: pop moves the tail forward, push fills the first free slot
  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    e0_d = e0_q;
    e1_d = e1_q;
    if (pop) begin
      v0_d = v1_q;
      e0_d = e1_q;
      v1_d = 1'b0;
    end
    if (push_i) begin
      if (!v0_d) begin
        v0_d = 1'b1;
        e0_d = data_i;
      end else begin
        v1_d = 1'b1;
        e1_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign full_o  = v1_q;
  assign valid_o = v0_q;
  assign data_o  = e0_q;

endmodule

// ----- rtl/motor_current_pinch_detector.sv -----
// Top level of the motor current pinch detector: control state, window chain, result buffer.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | in        | in_valid_i/in_stall_o | in_i  (mcpd_pkg::in_t)
//  out      | out       | out_valid_o/out_stall_i | out_o (mcpd_pkg::out_t)
//  cfg      | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; its result enters the output buffer in the next cycle.
// The whole update (window push, sum, average compare, counters) is one register stage.
// Reset clears all control state and loads the register defaults; no clearing pass.
// A two-entry result buffer lets requests flow while one result waits; in_stall_o
// rises only when both entries are occupied.
module motor_current_pinch_detector #(
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mcpd_pkg::in_t                     in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mcpd_pkg::out_t                    out_o,
  input  logic                              cfg_we_i,
  input  logic [mcpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcpd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW_DEPTH * 32768 + 1);
  localparam int unsigned PROD_W = 16 + CNT_W;
  localparam int unsigned CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  // configuration registers
  logic [15:0] hard_thr_q, soft_thr_q, ignore_ms_q;
  logic [7:0]  hard_lim_q, soft_lim_q;
  logic        stop_en_q;

  // detector state
  logic             latch_q, latch_d;
  logic [7:0]       hard_cnt_q, hard_cnt_d, soft_cnt_q, soft_cnt_d;
  logic             moving_q, moving_d;
  logic [31:0]      start_time_q, start_time_d;
  logic [31:0]      deadline_q, deadline_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] fill_q, fill_d;

  logic           accept;
  logic           push;
  logic           full;
  logic [15:0]    cur;
  logic [15:0]    tap [WINDOW_DEPTH];
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  fill_new;
  logic [PROD_W-1:0] avg_ref;
  logic [31:0]    since_sus, since_start;
  logic [7:0]     hard_cnt_new, soft_cnt_new;
  logic           trip;
  logic [2:0]     status;
  mcpd_pkg::out_t result;
  logic           buf_full;

  assign accept     = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_thr_q  <= mcpd_pkg::HARD_THR_RST;
      soft_thr_q  <= mcpd_pkg::SOFT_THR_RST;
      hard_lim_q  <= mcpd_pkg::HARD_LIM_RST;
      soft_lim_q  <= mcpd_pkg::SOFT_LIM_RST;
      ignore_ms_q <= mcpd_pkg::IGNORE_MS_RST;
      stop_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcpd_pkg::REG_HARD_THR:  hard_thr_q  <= cfg_data_i;
        mcpd_pkg::REG_SOFT_THR:  soft_thr_q  <= cfg_data_i;
        mcpd_pkg::REG_HARD_LIM:  hard_lim_q  <= cfg_data_i[7:0];
        mcpd_pkg::REG_SOFT_LIM:  soft_lim_q  <= cfg_data_i[7:0];
        mcpd_pkg::REG_IGNORE_MS: ignore_ms_q <= cfg_data_i;
        mcpd_pkg::REG_STOP_EN:   stop_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // current magnitude; the most negative reading gives 32768
  assign cur = in_i.shunt_raw[15] ? (~in_i.shunt_raw + 16'd1) : in_i.shunt_raw;

  // window chain: new sample enters cell 0, oldest leaves the last cell
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      mcpd_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (push),
        .data_i     (cur),
        .data_o     (tap[k])
      );
    end else begin : g_body
      mcpd_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (push),
        .data_i     (tap[k-1]),
        .data_o     (tap[k])
      );
    end
  end

  // window sum and fill after a push
  assign full     = (fill_q == CNT_W'(WINDOW_DEPTH));
  assign sum_new  = sum_q - (full ? SUM_W'(tap[WINDOW_DEPTH-1]) : '0) + SUM_W'(cur);
  assign fill_new = full ? fill_q : fill_q + CNT_W'(1);
  assign avg_ref  = PROD_W'(soft_thr_q) * PROD_W'(fill_new);

  assign since_sus   = in_i.now_ms - deadline_q;
  assign since_start = in_i.now_ms - start_time_q;

  // saturating exceedance counters
  assign hard_cnt_new = (cur >= hard_thr_q) ?
                        ((hard_cnt_q == mcpd_pkg::COUNT_MAX) ? hard_cnt_q : hard_cnt_q + 8'd1)
                        : 8'd0;
  assign soft_cnt_new = (CMP_W'(sum_new) >= CMP_W'(avg_ref)) ?
                        ((soft_cnt_q == mcpd_pkg::COUNT_MAX) ? soft_cnt_q : soft_cnt_q + 8'd1)
                        : 8'd0;

  // request decode and next state
  always_comb begin
    latch_d      = latch_q;
    hard_cnt_d   = hard_cnt_q;
    soft_cnt_d   = soft_cnt_q;
    moving_d     = moving_q;
    start_time_d = start_time_q;
    deadline_d   = deadline_q;
    sum_d        = sum_q;
    fill_d       = fill_q;
    push         = 1'b0;
    trip         = 1'b0;
    status       = mcpd_pkg::ST_CMD_DONE;
    if (accept) begin
      unique case (in_i.opcode) inside
        mcpd_pkg::OP_SAMPLE: begin
          if (latch_q) begin
            status = mcpd_pkg::ST_FROZEN;
          end else if (since_sus[31] || !in_i.motor_moving) begin
            hard_cnt_d   = 8'd0;
            soft_cnt_d   = 8'd0;
            moving_d     = 1'b0;
            start_time_d = 32'd0;
            sum_d        = '0;
            fill_d       = '0;
            status = since_sus[31] ? mcpd_pkg::ST_SUSPENDED : mcpd_pkg::ST_IDLE;
          end else if (!moving_q) begin
            moving_d     = 1'b1;
            start_time_d = in_i.now_ms;
            hard_cnt_d   = 8'd0;
            soft_cnt_d   = 8'd0;
            sum_d        = '0;
            fill_d       = '0;
            status       = mcpd_pkg::ST_START;
          end else if (since_start < {16'd0, ignore_ms_q} || !in_i.read_ok) begin
            hard_cnt_d = 8'd0;
            soft_cnt_d = 8'd0;
            sum_d      = '0;
            fill_d     = '0;
            status = (since_start < {16'd0, ignore_ms_q}) ? mcpd_pkg::ST_IGNORE
                                                          : mcpd_pkg::ST_READ_FAIL;
          end else begin
            push       = 1'b1;
            sum_d      = sum_new;
            fill_d     = fill_new;
            hard_cnt_d = hard_cnt_new;
            soft_cnt_d = soft_cnt_new;
            trip       = (hard_cnt_new >= hard_lim_q) || (soft_cnt_new >= soft_lim_q);
            if (trip && stop_en_q) begin
              latch_d = 1'b1;
            end
            status = mcpd_pkg::ST_EVAL;
          end
        end
        mcpd_pkg::OP_CLEAR, mcpd_pkg::OP_SUSPEND: begin
          latch_d      = 1'b0;
          hard_cnt_d   = 8'd0;
          soft_cnt_d   = 8'd0;
          moving_d     = 1'b0;
          start_time_d = 32'd0;
          sum_d        = '0;
          fill_d       = '0;
          deadline_d   = (in_i.opcode == mcpd_pkg::OP_SUSPEND) ?
                         in_i.now_ms + in_i.hold_ms : 32'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q      <= 1'b0;
      hard_cnt_q   <= 8'd0;
      soft_cnt_q   <= 8'd0;
      moving_q     <= 1'b0;
      start_time_q <= 32'd0;
      deadline_q   <= 32'd0;
      sum_q        <= '0;
      fill_q       <= '0;
    end else begin
      latch_q      <= latch_d;
      hard_cnt_q   <= hard_cnt_d;
      soft_cnt_q   <= soft_cnt_d;
      moving_q     <= moving_d;
      start_time_q <= start_time_d;
      deadline_q   <= deadline_d;
      sum_q        <= sum_d;
      fill_q       <= fill_d;
    end
  end

  // result of this request
  always_comb begin
    result.detected       = latch_d;
    result.trip           = trip;
    result.hard_count_out = hard_cnt_d;
    result.soft_count_out = soft_cnt_d;
    result.window_total   = 19'(sum_d);
    result.window_fill    = 4'(fill_d);
    result.status         = status;
  end

  mcpd_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_o)
  );

endmodule

// ----- rtl/mcpd_checker.sv -----
// Port-level checks of the motor current pinch detector, bound to the top level.
module mcpd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mcpd_pkg::out_t out_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // requests are only held off while results are pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty result buffer");

  // trip only on an evaluated sample
  a_trip_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.trip |-> out_o.status == mcpd_pkg::ST_EVAL)
    else $error("trip outside evaluation");

  // frozen results come only from a latched detector
  a_frozen_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == mcpd_pkg::ST_FROZEN |-> out_o.detected)
    else $error("frozen status without latch");

  // idle, suspended and motion start leave counters and window empty
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == mcpd_pkg::ST_IDLE ||
                    out_o.status == mcpd_pkg::ST_SUSPENDED ||
                    out_o.status == mcpd_pkg::ST_START)
    |-> out_o.hard_count_out == 8'd0 && out_o.soft_count_out == 8'd0 &&
        out_o.window_fill == 4'd0 && out_o.window_total == 19'd0)
    else $error("state not cleared");

endmodule

bind motor_current_pinch_detector mcpd_checker u_mcpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

// ----- verif/mcpd_pinch_checker.sv -----
`timescale 1ns / 100ps
// Checker for the pinch detector: it watches all channels, predicts every result and compares.
module mcpd_pinch_checker #(
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  mcpd_pkg::in_t                     in_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  mcpd_pkg::out_t                    out_i,
  input  logic                              cfg_we_i,
  input  logic [mcpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcpd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       checked_o,
  output int unsigned                       trips_o
);

  // Local copy of the register file
  logic [15:0] hard_thr, soft_thr, ignore_ms;
  logic [7:0]  hard_lim, soft_lim;
  logic        stop_en;

  // Local copy of the detector state
  logic        latched, was_moving;
  logic [7:0]  hard_cnt, soft_cnt;
  logic [31:0] motion_start, suspend_until;
  logic [16:0] win_mag [WINDOW_DEPTH];
  logic [31:0] win_sum;
  logic [6:0]  win_ptr, win_fill;

  // Results predicted for accepted requests, oldest first
  mcpd_pkg::out_t awaited_q [$];
  int unsigned mismatch_n = 0;
  int unsigned checked_n  = 0;
  int unsigned trips_n    = 0;

  assign fail_count_o = mismatch_n;
  assign checked_o    = checked_n;
  assign trips_o      = trips_n;

  task automatic report_mismatch(input string msg);
    mismatch_n++;
    $display("[%0t] pinch check: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    end
  endtask

  function automatic void drop_window();
    win_sum  = '0;
    win_ptr  = '0;
    win_fill = '0;
  endfunction

  function automatic void drop_counts();
    hard_cnt = '0;
    soft_cnt = '0;
  endfunction

  // Motor considered stopped: counters, motion tracking and window all go
  function automatic void drop_motion();
    drop_counts();
    drop_window();
    was_moving   = 1'b0;
    motion_start = '0;
  endfunction

  function automatic void clear_all();
    drop_motion();
    latched       = 1'b0;
    suspend_until = '0;
    foreach (win_mag[k]) win_mag[k] = '0;
  endfunction

  // Advance the local state by one request and return the result it yields
  function automatic mcpd_pkg::out_t predict_pinch(input mcpd_pkg::in_t req);
    mcpd_pkg::out_t res;
    logic [16:0] mag;
    logic [31:0] lapse, since_start;
    logic [47:0] sum_w, need_w;
    logic        trip;
    logic [2:0]  st;
    trip        = 1'b0;
    st          = mcpd_pkg::ST_CMD_DONE;
    lapse       = req.now_ms - suspend_until;
    since_start = req.now_ms - motion_start;
    case (req.opcode)
      mcpd_pkg::OP_SAMPLE: begin
        if (latched) begin
          st = mcpd_pkg::ST_FROZEN;
        end else if (lapse[31]) begin
          drop_motion();
          st = mcpd_pkg::ST_SUSPENDED;
        end else if (!req.motor_moving) begin
          drop_motion();
          st = mcpd_pkg::ST_IDLE;
        end else if (!was_moving) begin
          drop_counts();
          drop_window();
          was_moving   = 1'b1;
          motion_start = req.now_ms;
          st = mcpd_pkg::ST_START;
        end else if (since_start < {16'd0, ignore_ms}) begin
          drop_counts();
          drop_window();
          st = mcpd_pkg::ST_IGNORE;
        end else if (!req.read_ok) begin
          drop_counts();
          drop_window();
          st = mcpd_pkg::ST_READ_FAIL;
        end else begin
          // magnitude of the shunt reading, 32768 for the most negative code
          mag = req.shunt_raw[15] ? 17'h10000 - {1'b0, req.shunt_raw}
                                  : {1'b0, req.shunt_raw};
          if (win_fill < WINDOW_DEPTH) begin
            win_fill++;
          end else begin
            win_sum = win_sum - win_mag[win_ptr];
          end
          win_mag[win_ptr] = mag;
          win_sum = win_sum + mag;
          win_ptr = (win_ptr + 7'd1 >= WINDOW_DEPTH) ? '0 : win_ptr + 7'd1;

          if (mag >= hard_thr) begin
            if (hard_cnt != mcpd_pkg::COUNT_MAX) hard_cnt++;
          end else begin
            hard_cnt = '0;
          end

          // average test without division: sum against threshold times fill
          sum_w  = win_sum;
          need_w = soft_thr;
          need_w = need_w * win_fill;
          if (sum_w >= need_w) begin
            if (soft_cnt != mcpd_pkg::COUNT_MAX) soft_cnt++;
          end else begin
            soft_cnt = '0;
          end

          if (hard_cnt >= hard_lim || soft_cnt >= soft_lim) begin
            trip = 1'b1;
            if (stop_en) latched = 1'b1;
          end
          st = mcpd_pkg::ST_EVAL;
        end
      end
      mcpd_pkg::OP_CLEAR: begin
        clear_all();
      end
      mcpd_pkg::OP_SUSPEND: begin
        drop_motion();
        latched       = 1'b0;
        suspend_until = req.now_ms + req.hold_ms;
      end
      default: ;
    endcase
    res.detected       = latched;
    res.trip           = trip;
    res.hard_count_out = hard_cnt;
    res.soft_count_out = soft_cnt;
    res.window_total   = win_sum[18:0];
    res.window_fill    = win_fill[3:0];
    res.status         = st;
    return res;
  endfunction

  // Monitor: register writes, result compare, then prediction for new requests
  always @(posedge clk_i or negedge rst_ni) begin
    mcpd_pkg::out_t want;
    if (!rst_ni) begin
      hard_thr  = mcpd_pkg::HARD_THR_RST;
      soft_thr  = mcpd_pkg::SOFT_THR_RST;
      hard_lim  = mcpd_pkg::HARD_LIM_RST;
      soft_lim  = mcpd_pkg::SOFT_LIM_RST;
      ignore_ms = mcpd_pkg::IGNORE_MS_RST;
      stop_en   = 1'b0;
      clear_all();
      awaited_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mcpd_pkg::REG_HARD_THR:  hard_thr  = cfg_data_i;
          mcpd_pkg::REG_SOFT_THR:  soft_thr  = cfg_data_i;
          mcpd_pkg::REG_HARD_LIM:  hard_lim  = cfg_data_i[7:0];
          mcpd_pkg::REG_SOFT_LIM:  soft_lim  = cfg_data_i[7:0];
          mcpd_pkg::REG_IGNORE_MS: ignore_ms = cfg_data_i;
          mcpd_pkg::REG_STOP_EN:   stop_en   = cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = awaited_q.pop_front();
          checked_n++;
          if (want.trip) trips_n++;
          check_field("detected", out_i.detected, want.detected);
          check_field("trip", out_i.trip, want.trip);
          check_field("hard_count_out", out_i.hard_count_out, want.hard_count_out);
          check_field("soft_count_out", out_i.soft_count_out, want.soft_count_out);
          check_field("window_total", out_i.window_total, want.window_total);
          check_field("window_fill", out_i.window_fill, want.window_fill);
          check_field("status", out_i.status, want.status);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        awaited_q.push_back(predict_pinch(in_i));
      end
      pending_o <= awaited_q.size();
    end
  end

endmodule

// ----- verif/tb_motor_current_pinch_detector.sv -----
`timescale 1ns / 100ps
// Testbench top for the pinch detector: clock, reset, request stimulus and the verdict.
module tb_motor_current_pinch_detector;

  // opcode with no function; the block must answer it and change nothing
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned NUM_SETTINGS = 7;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  mcpd_pkg::in_t                   in_req    = '0;
  logic                            out_stall = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [mcpd_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [mcpd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_stall, out_valid;
  mcpd_pkg::out_t                  out_res;
  int unsigned                     fail_count, pending, checked, trips;

  // stimulus shaping
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 79;
  int unsigned noise_pm      = 20;
  int unsigned hot_pct       = 15;
  logic [15:0] hard_thr_now  = mcpd_pkg::HARD_THR_RST;
  logic [15:0] soft_thr_now  = mcpd_pkg::SOFT_THR_RST;
  logic [31:0] clock_ms      = '0;
  logic [31:0] deadline_hint = '0;
  int unsigned sent_n        = 0;
  int unsigned quiet_n       = 0;

  motor_current_pinch_detector u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  mcpd_pinch_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_i         (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_i        (out_res),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .trips_o      (trips)
  );

  always #5 clk = ~clk;

  // Result side back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: too long without any handshake or register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_n <= 0;
      end else if (quiet_n == QUIET_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_n <= quiet_n + 1;
      end
    end
  end

  function automatic mcpd_pkg::in_t make_req(input logic [1:0] op, input logic [31:0] now,
                                             input logic moving, input logic ok,
                                             input logic [15:0] raw, input logic [31:0] sus);
    mcpd_pkg::in_t r;
    r.opcode       = op;
    r.now_ms       = now;
    r.motor_moving = moving;
    r.read_ok      = ok;
    r.shunt_raw    = raw;
    r.hold_ms      = sus;
    return r;
  endfunction

  // Offer one request, idling at random first, and wait until it is taken
  task automatic send_req(input mcpd_pkg::in_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    sent_n++;
    if (req.opcode == mcpd_pkg::OP_SUSPEND) begin
      deadline_hint = req.now_ms + req.hold_ms;
    end else if (req.opcode == mcpd_pkg::OP_CLEAR) begin
      deadline_hint = '0;
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [mcpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mcpd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Register settings per random phase, with matching stimulus mix
  task automatic program_setting(input int unsigned idx, output int unsigned n_items);
    logic [15:0] hthr, sthr, ign;
    logic [7:0]  hlim, slim;
    logic        stop;
    hot_pct = 15;
    case (idx)
      0: begin  // power-on values
        hthr = mcpd_pkg::HARD_THR_RST; sthr = mcpd_pkg::SOFT_THR_RST;
        hlim = mcpd_pkg::HARD_LIM_RST; slim = mcpd_pkg::SOFT_LIM_RST;
        ign = mcpd_pkg::IGNORE_MS_RST; stop = 1'b0;
        noise_pm = 20; n_items = 130;
      end
      1: begin  // all zero: every evaluated sample trips and latches
        hthr = '0; sthr = '0; hlim = '0; slim = '0; ign = '0; stop = 1'b1;
        noise_pm = 100; n_items = 90;
      end
      2: begin  // all at maximum
        hthr = 16'hFFFF; sthr = 16'hFFFF; hlim = 8'hFF; slim = 8'hFF;
        ign = 16'hFFFF; stop = 1'b0;
        noise_pm = 30; n_items = 120;
      end
      3: begin
        hthr = 16'd12000; sthr = 16'd8000; hlim = 8'd3; slim = 8'd5;
        ign = 16'd40; stop = 1'b1;
        noise_pm = 60; n_items = 130;
      end
      4: begin
        hthr = 16'd20000; sthr = 16'd16000; hlim = 8'd1; slim = 8'd1;
        ign = 16'd0; stop = 1'b0;
        noise_pm = 25; n_items = 120;
      end
      5: begin
        hthr = 16'd5000; sthr = 16'd30000; hlim = 8'd8; slim = 8'd2;
        ign = 16'd100; stop = 1'b1;
        noise_pm = 60; n_items = 130;
      end
      default: begin  // long clean run of heavy current: both counters saturate
        hthr = 16'd100; sthr = 16'd100; hlim = 8'd200; slim = 8'd255;
        ign = 16'd0; stop = 1'b0;
        noise_pm = 0; hot_pct = 100; n_items = 300;
      end
    endcase
    write_reg(mcpd_pkg::REG_HARD_THR, hthr);
    write_reg(mcpd_pkg::REG_SOFT_THR, sthr);
    write_reg(mcpd_pkg::REG_HARD_LIM, {8'd0, hlim});
    write_reg(mcpd_pkg::REG_SOFT_LIM, {8'd0, slim});
    write_reg(mcpd_pkg::REG_IGNORE_MS, ign);
    write_reg(mcpd_pkg::REG_STOP_EN, {15'd0, stop});
    hard_thr_now = hthr;
    soft_thr_now = sthr;
  endtask

  // Current magnitude within a few thousand units of a trip level
  function automatic logic [16:0] near_level(input logic [15:0] level);
    int v;
    v = level;
    v = v + $urandom_range(6000, 0);
    v = v - 3000;
    if (v < 0) v = 0;
    if (v > 32768) v = 32768;
    return 17'(v);
  endfunction

  // Mostly well-formed moving samples 0 to 40 ms apart; the rest breaks the sequence
  task automatic make_random_req(output mcpd_pkg::in_t req);
    int unsigned pick;
    logic [16:0] magv;
    pick = $urandom_range(999);
    if (pick < 20) begin
      clock_ms = ($urandom_range(3) == 0) ? $urandom()
                                          : deadline_hint + $urandom_range(32'h7FFF_FFFF, 0);
    end else begin
      clock_ms = clock_ms + $urandom_range(40, 0);
    end
    req.now_ms       = clock_ms;
    req.hold_ms      = $urandom();
    req.motor_moving = ($urandom_range(999) >= noise_pm / 4);
    req.read_ok      = ($urandom_range(999) >= noise_pm / 4);

    pick = $urandom_range(99);
    if (pick < hot_pct) magv = 17'($urandom_range(32768, 16384));
    else if (pick < 55) magv = near_level(hard_thr_now);
    else if (pick < 90) magv = near_level(soft_thr_now);
    else magv = 17'($urandom_range(32768, 0));
    if (magv[15]) begin
      req.shunt_raw = 16'h8000;
    end else if ($urandom_range(1) == 1) begin
      req.shunt_raw = 16'h0000 - magv[15:0];
    end else begin
      req.shunt_raw = magv[15:0];
    end

    req.opcode = mcpd_pkg::OP_SAMPLE;
    if ($urandom_range(999) < noise_pm / 2) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        req.opcode  = mcpd_pkg::OP_SUSPEND;
        req.hold_ms = (pick == 0) ? $urandom() : $urandom_range(200, 0);
      end else if (pick < 9) begin
        req.opcode = mcpd_pkg::OP_CLEAR;
      end else begin
        req.opcode = OP_SPARE;
      end
    end
  endtask

  // Directed walk through every status and the corner cases
  task automatic run_directed();
    logic [15:0] raw;
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd0, 1'b0, 1'b1, 16'h0000, 32'd0));
    send_req(make_req(OP_SPARE, 32'd5, 1'b1, 1'b1, 16'h7FFF, 32'hFFFF_FFFF));
    send_req(make_req(mcpd_pkg::OP_SUSPEND, 32'd1000, 1'b0, 1'b0, 16'h0000, 32'd500));
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd1200, 1'b1, 1'b1, 16'h1000, 32'd0));
    // deadline reached: motion starts, then the start-up window, then a failed reading
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd1500, 1'b1, 1'b1, 16'h1000, 32'd0));
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd1799, 1'b1, 1'b1, 16'h1000, 32'd0));
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd1800, 1'b1, 1'b0, 16'h1000, 32'd0));
    // reading extremes, soft counter reaches its limit
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd1820, 1'b1, 1'b1, 16'h7FFF, 32'd0));
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd1840, 1'b1, 1'b1, 16'h8000, 32'd0));
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd1860, 1'b1, 1'b1, 16'hFFFF, 32'd0));
    // enough samples to wrap the window
    for (int unsigned k = 0; k < 8; k++) begin
      raw = 16'(k * 4100);
      if (k % 2 == 1) raw = 16'h0000 - raw;
      send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'd1880 + k * 20, 1'b1, 1'b1, raw, 32'd0));
    end
    send_req(make_req(mcpd_pkg::OP_CLEAR, 32'd2100, 1'b1, 1'b1, 16'h0000, 32'd0));
    // deadline wraps past zero
    send_req(make_req(mcpd_pkg::OP_SUSPEND, 32'hFFFF_FFF0, 1'b1, 1'b1, 16'h0000, 32'h20));
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'hFFFF_FFF8, 1'b1, 1'b1, 16'h0000, 32'd0));
    // zero limit with latching: trip, then frozen, then released by suspend
    wait_drained();
    write_reg(mcpd_pkg::REG_STOP_EN, 16'd1);
    write_reg(mcpd_pkg::REG_HARD_LIM, 16'd0);
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'h10, 1'b1, 1'b1, 16'd100, 32'd0));
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'h200, 1'b1, 1'b1, 16'd100, 32'd0));
    send_req(make_req(mcpd_pkg::OP_SAMPLE, 32'h214, 1'b1, 1'b1, 16'd100, 32'd0));
    send_req(make_req(mcpd_pkg::OP_SUSPEND, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000,
                      32'hFFFF_FFFF));
  endtask

  initial begin
    mcpd_pkg::in_t req;
    int unsigned   n_items;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int unsigned s = 0; s < NUM_SETTINGS; s++) begin
      if (s == 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 17;
      end else if (s == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      program_setting(s, n_items);
      clock_ms = deadline_hint + 32'd1000;
      for (int unsigned i = 0; i < n_items; i++) begin
        // sender holds off mid-phase until the block has gone empty
        if (i == n_items / 2) wait_drained();
        make_random_req(req);
        send_req(req);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests: directed walk, then %0d register settings under three idle mixes.",
             sent_n, NUM_SETTINGS);
    $display("Checked %0d results, %0d of them trips; %0d mismatches.",
             checked, trips, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
